[hw/rtl/dblg_pkg.sv]
// ----------------------------------------------------------------------------
// dblg_pkg
// Shared constants for the distance band leg grouping unit.
// ----------------------------------------------------------------------------
package dblg_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int MAX_RESULTS    = 32;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 12;
    localparam int ORD_W   = 6;
    localparam int POINT_W = 2 * COORD_W;

    localparam logic [DIST_W-1:0] MIN_DIST_RST = 12'd200;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 12'd600;

    // configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DIST = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DIST = 1'd1;

endpackage

[hw/rtl/distance_band_leg_grouping_unit.sv]
// ----------------------------------------------------------------------------
// distance_band_leg_grouping_unit
// Collects a set of 2-D points and reports anchors with exactly three
// neighbors inside a distance band, with a blended center per detection.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while o_busy is low; an item is accepted
// when i_start is high and o_busy is low. The item with i_set_end high is
// stored too and then closes the set. A set of fewer than three points gives
// no result and o_busy stays low. Otherwise o_busy rises for the evaluation,
// which scans every ordered pair through the single read port of the point
// RAM, one pair after another (the result limit can end the scan early).
// Results appear on the o_ ports for exactly one cycle each, marked by o_valid,
// and cannot be held off; the last result of a set carries o_run_end.
// Configuration writes are taken at any time but belong to idle periods.
// ----------------------------------------------------------------------------
module distance_band_leg_grouping_unit #(
    parameter int MAX_POINTS = dblg_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item channel
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [dblg_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [dblg_pkg::COORD_W-1:0] i_point_y,
    input  logic                               i_set_end,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [dblg_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dblg_pkg::DIST_W-1:0]         i_cfg_wdata,
    // results
    output logic                               o_valid,
    output logic                               o_found,
    output logic signed [dblg_pkg::COORD_W-1:0] o_center_x,
    output logic signed [dblg_pkg::COORD_W-1:0] o_center_y,
    output logic [dblg_pkg::ORD_W-1:0]          o_ordinal,
    output logic [dblg_pkg::ORD_W-1:0]          o_anchor_index,
    output logic                               o_overflowed,
    output logic                               o_run_end
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = dblg_pkg::COORD_W;
    localparam int DW    = dblg_pkg::DIST_W;
    localparam int OW    = dblg_pkg::ORD_W;
    localparam int PW    = dblg_pkg::POINT_W;
    localparam int SQ_W  = 2 * CW;        // square of a coordinate difference
    localparam int D2_W  = SQ_W + 1;      // sum of two squares
    localparam int BD2_W = 2 * DW;        // squared band bound

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ARD  = 4'd1;
    localparam logic [3:0] S_ALAT = 4'd2;
    localparam logic [3:0] S_JRD  = 4'd3;
    localparam logic [3:0] S_DIFF = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_AEND = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // floor((3a + 3b + 2c) / 8)
    function automatic logic signed [CW-1:0] blend(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c
    );
        logic signed [CW+2:0] ea;
        logic signed [CW+2:0] eb;
        logic signed [CW+2:0] ec;
        logic signed [CW+2:0] s;
        ea = {{3{a[CW-1]}}, a};
        eb = {{3{b[CW-1]}}, b};
        ec = {{3{c[CW-1]}}, c};
        s  = (ea <<< 1) + ea + (eb <<< 1) + eb + (ec <<< 1);
        return s[CW+2:3];
    endfunction

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [DW-1:0]           r_min_dist;
    logic [DW-1:0]           r_max_dist;
    logic [BD2_W-1:0]        r_lo2;
    logic [BD2_W-1:0]        r_hi2;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic [IDX_W-1:0]        r_last;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic signed [CW-1:0]    r_ax;
    logic signed [CW-1:0]    r_ay;
    logic signed [CW-1:0]    r_jx;
    logic signed [CW-1:0]    r_jy;
    logic signed [CW:0]      r_dx;
    logic signed [CW:0]      r_dy;
    logic [SQ_W-1:0]         r_sx;
    logic [SQ_W-1:0]         r_sy;
    logic [2:0]              r_cnt;
    logic signed [CW-1:0]    r_nb_x [3];
    logic signed [CW-1:0]    r_nb_y [3];
    logic [OW-1:0]           r_nres;
    logic                    r_pv;
    logic signed [CW-1:0]    r_px;
    logic signed [CW-1:0]    r_py;
    logic [OW-1:0]           r_pord;
    logic [OW-1:0]           r_panc;

    logic                    r_valid;
    logic                    r_found;
    logic signed [CW-1:0]    r_cx;
    logic signed [CW-1:0]    r_cy;
    logic [OW-1:0]           r_ord;
    logic [OW-1:0]           r_anc;
    logic                    r_ovf_o;
    logic                    r_run_end;

    logic                    accept;
    logic                    store_we;
    logic [CNT_W-1:0]        count_after;
    logic [IDX_W-1:0]        rd_addr;
    logic [PW-1:0]           rd_data;
    logic signed [SQ_W+1:0]  sq_x;
    logic signed [SQ_W+1:0]  sq_y;
    logic [D2_W-1:0]         d2;
    logic                    in_band;
    logic signed [CW-1:0]    bx;
    logic signed [CW-1:0]    by;
    logic                    detect;
    logic                    res_full;

    assign accept      = i_start && (r_state == S_IDLE);
    assign store_we    = accept && (r_count < CNT_W'(MAX_POINTS));
    assign count_after = store_we ? r_count + CNT_W'(1) : r_count;
    assign rd_addr     = (r_state == S_ARD) ? r_i : r_j;

    assign sq_x    = r_dx * r_dx;
    assign sq_y    = r_dy * r_dy;
    assign d2      = {1'b0, r_sx} + {1'b0, r_sy};
    assign in_band = (r_j != r_i)
                  && (d2 > D2_W'(r_lo2))
                  && (d2 < D2_W'(r_hi2));

    assign bx       = blend(r_nb_x[0], r_nb_x[1], r_nb_x[2]);
    assign by       = blend(r_nb_y[0], r_nb_y[1], r_nb_y[2]);
    assign detect   = (r_cnt == 3'd3);
    assign res_full = detect && ((r_nres + OW'(1)) == OW'(dblg_pkg::MAX_RESULTS));

    dblg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_set_end && (count_after >= CNT_W'(3))) begin
                    n_state = S_ARD;
                end
            end
            S_ARD:  n_state = S_ALAT;
            S_ALAT: n_state = S_JRD;
            S_JRD:  n_state = S_DIFF;
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_CMP;
            S_CMP:  n_state = (r_j == r_last) ? S_AEND : S_JRD;
            S_AEND: n_state = (res_full || (r_i == r_last)) ? S_FIN : S_ARD;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min_dist <= dblg_pkg::MIN_DIST_RST;
            r_max_dist <= dblg_pkg::MAX_DIST_RST;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_pv       <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dblg_pkg::REG_MIN_DIST: r_min_dist <= i_cfg_wdata;
                    dblg_pkg::REG_MAX_DIST: r_max_dist <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_set_end && (count_after < CNT_W'(3))) begin
                    // small set closes without a result
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= count_after;
                    if (!store_we) begin
                        r_ovf <= 1'b1;
                    end
                end
                r_pv <= 1'b0;
            end
            if ((r_state == S_AEND) && detect) begin
                r_pv <= 1'b1;
                // a newer detection pushes the held one out
                if (r_pv) begin
                    r_valid <= 1'b1;
                end
            end
            if (r_state == S_FIN) begin
                r_valid <= 1'b1;
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_pv    <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_lo2 <= r_min_dist * r_min_dist;
        r_hi2 <= r_max_dist * r_max_dist;
        unique case (r_state)
            S_IDLE: begin
                r_i    <= '0;
                r_nres <= '0;
                r_last <= IDX_W'(count_after - CNT_W'(1));
            end
            S_ALAT: begin
                r_ax  <= rd_data[PW-1:CW];
                r_ay  <= rd_data[CW-1:0];
                r_j   <= '0;
                r_cnt <= '0;
            end
            S_DIFF: begin
                r_jx <= rd_data[PW-1:CW];
                r_jy <= rd_data[CW-1:0];
                r_dx <= {r_ax[CW-1], r_ax} - {rd_data[PW-1], rd_data[PW-1:CW]};
                r_dy <= {r_ay[CW-1], r_ay} - {rd_data[CW-1], rd_data[CW-1:0]};
            end
            S_SQ: begin
                r_sx <= sq_x[SQ_W-1:0];
                r_sy <= sq_y[SQ_W-1:0];
            end
            S_CMP: begin
                if (in_band) begin
                    if (r_cnt < 3'd3) begin
                        r_nb_x[r_cnt[1:0]] <= r_jx;
                        r_nb_y[r_cnt[1:0]] <= r_jy;
                    end
                    // saturate past three, one more is enough to reject
                    if (r_cnt != 3'd4) begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                r_j <= r_j + IDX_W'(1);
            end
            S_AEND: begin
                if (detect) begin
                    r_found   <= 1'b1;
                    r_cx      <= r_px;
                    r_cy      <= r_py;
                    r_ord     <= r_pord;
                    r_anc     <= r_panc;
                    r_ovf_o   <= r_ovf;
                    r_run_end <= 1'b0;
                    r_px      <= bx;
                    r_py      <= by;
                    r_pord    <= r_nres;
                    r_panc    <= OW'(r_i);
                    r_nres    <= r_nres + OW'(1);
                end
                r_i <= r_i + IDX_W'(1);
            end
            S_FIN: begin
                r_found   <= r_pv;
                r_cx      <= r_pv ? r_px : '0;
                r_cy      <= r_pv ? r_py : '0;
                r_ord     <= r_pv ? r_pord : '0;
                r_anc     <= r_pv ? r_panc : '0;
                r_ovf_o   <= r_ovf;
                r_run_end <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_center_x     = r_cx;
    assign o_center_y     = r_cy;
    assign o_ordinal      = r_ord;
    assign o_anchor_index = r_anc;
    assign o_overflowed   = r_ovf_o;
    assign o_run_end      = r_run_end;

endmodule

[hw/rtl/dblg_ram.sv]
// ----------------------------------------------------------------------------
// dblg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dblg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_distance_band_leg_grouping_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_band_leg_grouping_unit
// Sends sets of 2-D points to the leg grouping unit and checks every
// detection it reports. Expected detections are computed from the point sets
// with the current distance band. The sender idles at random and waits out
// the evaluation, and the band changes between phases. The run starts with
// a few directed sets, then continues with random legs, clumps, noise and
// oversized sets.
// ----------------------------------------------------------------------------
module tb_distance_band_leg_grouping_unit;
    import dblg_pkg::*;

    localparam int POINT_CAP     = MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int IDLE_PCT      = 12;
    localparam int NUM_PHASES    = 6;
    localparam int SET_MAX       = 48;

    typedef struct {
        logic                      found;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [ORD_W-1:0]          ord;
        logic [ORD_W-1:0]          anchor;
        logic                      ovf;
        logic                      run_end;
    } t_detection;

    class leg_detection_board;
        int          store_x[POINT_CAP];
        int          store_y[POINT_CAP];
        int          point_count;
        bit          overflow_seen;
        int          lo_mm;
        int          hi_mm;
        t_detection  detections_due[$];
        int          mismatch_count;

        function new();
            point_count    = 0;
            overflow_seen  = 1'b0;
            lo_mm          = MIN_DIST_RST;
            hi_mm          = MAX_DIST_RST;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
            case (idx)
                REG_MIN_DIST: lo_mm = val;
                REG_MAX_DIST: hi_mm = val;
                default: ;
            endcase
        endfunction

        // floor of (3a + 3b + 2c) / 8
        function int blend_axis(int a, int b, int c);
            return (3 * a + 3 * b + 2 * c) >>> 3;
        endfunction

        function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic last);
            longint     lo2, hi2, dx, dy, d2;
            int         nb[3];
            int         i, j, cnt, n;
            t_detection d;
            if (point_count < POINT_CAP) begin
                store_x[point_count] = x;
                store_y[point_count] = y;
                point_count++;
            end else begin
                overflow_seen = 1'b1;
            end
            if (!last)
                return;
            if (point_count >= 3) begin
                lo2 = longint'(lo_mm) * lo_mm;
                hi2 = longint'(hi_mm) * hi_mm;
                n   = 0;
                for (i = 0; i < point_count && n < MAX_RESULTS; i++) begin
                    cnt = 0;
                    for (j = 0; j < point_count; j++) begin
                        if (j != i) begin
                            dx = longint'(store_x[i]) - store_x[j];
                            dy = longint'(store_y[i]) - store_y[j];
                            d2 = dx * dx + dy * dy;
                            if (d2 > lo2 && d2 < hi2) begin
                                if (cnt < 3)
                                    nb[cnt] = j;
                                cnt++;
                            end
                        end
                    end
                    if (cnt == 3) begin
                        d.found   = 1'b1;
                        d.cx      = 16'(blend_axis(store_x[nb[0]], store_x[nb[1]],
                                                   store_x[nb[2]]));
                        d.cy      = 16'(blend_axis(store_y[nb[0]], store_y[nb[1]],
                                                   store_y[nb[2]]));
                        d.ord     = 6'(n);
                        d.anchor  = 6'(i);
                        d.ovf     = overflow_seen;
                        d.run_end = 1'b0;
                        detections_due = {detections_due, d};
                        n++;
                    end
                end
                if (n == 0) begin
                    d.found   = 1'b0;
                    d.cx      = '0;
                    d.cy      = '0;
                    d.ord     = '0;
                    d.anchor  = '0;
                    d.ovf     = overflow_seen;
                    d.run_end = 1'b1;
                    detections_due = {detections_due, d};
                end else begin
                    detections_due[detections_due.size() - 1].run_end = 1'b1;
                end
            end
            point_count   = 0;
            overflow_seen = 1'b0;
        endfunction

        function void check_result(t_detection got);
            t_detection want;
            if (detections_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: found=%0d cx=%0d cy=%0d ord=%0d anchor=%0d",
                             got.found, got.cx, got.cy, got.ord, got.anchor);
                return;
            end
            want = detections_due.pop_front();
            if (want.found !== got.found || want.cx !== got.cx || want.cy !== got.cy ||
                want.ord !== got.ord || want.anchor !== got.anchor ||
                want.ovf !== got.ovf || want.run_end !== got.run_end) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("expected found=%0d cx=%0d cy=%0d ord=%0d anchor=%0d ovf=%0d end=%0d",
                             want.found, want.cx, want.cy, want.ord, want.anchor,
                             want.ovf, want.run_end);
                    $display("actual   found=%0d cx=%0d cy=%0d ord=%0d anchor=%0d ovf=%0d end=%0d",
                             got.found, got.cx, got.cy, got.ord, got.anchor,
                             got.ovf, got.run_end);
                end
            end
        endfunction

        function int outstanding();
            return detections_due.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic                      i_set_end;
    logic                      i_cfg_we;
    logic [REG_IDX_W-1:0]      i_cfg_idx;
    logic [DIST_W-1:0]         i_cfg_wdata;
    logic                      o_valid;
    logic                      o_found;
    logic signed [COORD_W-1:0] o_center_x;
    logic signed [COORD_W-1:0] o_center_y;
    logic [ORD_W-1:0]          o_ordinal;
    logic [ORD_W-1:0]          o_anchor_index;
    logic                      o_overflowed;
    logic                      o_run_end;

    leg_detection_board        board;
    t_detection                seen;
    int                        cycle_count;
    bit                        idle_on;
    int                        cur_lo;
    int                        cur_hi;
    int                        items_sent;
    logic signed [COORD_W-1:0] set_x[SET_MAX];
    logic signed [COORD_W-1:0] set_y[SET_MAX];
    int                        set_len;

    distance_band_leg_grouping_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_set_end      (i_set_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_center_x     (o_center_x),
        .o_center_y     (o_center_y),
        .o_ordinal      (o_ordinal),
        .o_anchor_index (o_anchor_index),
        .o_overflowed   (o_overflowed),
        .o_run_end      (o_run_end)
    );

    always #2 i_clk = ~i_clk;

    // results are checked before the item of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                seen.found   = o_found;
                seen.cx      = o_center_x;
                seen.cy      = o_center_y;
                seen.ord     = o_ordinal;
                seen.anchor  = o_anchor_index;
                seen.ovf     = o_overflowed;
                seen.run_end = o_run_end;
                board.check_result(seen);
            end
            if (i_start && !o_busy)
                board.note_point(i_point_x, i_point_y, i_set_end);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int any_coord();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int wobble(int amt);
        return int'($urandom_range(0, 2 * amt)) - amt;
    endfunction

    function automatic void push_point(int x, int y);
        set_x[set_len] = 16'(x);
        set_y[set_len] = 16'(y);
        set_len++;
    endfunction

    function automatic void add_noise(int count);
        int k;
        for (k = 0; k < count; k++)
            push_point(any_coord(), any_coord());
    endfunction

    // square of legs with the given side, a fifth leg sits in the middle
    function automatic void add_legs(int side, int legs);
        int bx, by, jit, k;
        bx  = any_coord();
        by  = any_coord();
        jit = side / 8 + 1;
        for (k = 0; k < legs; k++) begin
            if (k == 4)
                push_point(bx + side / 2 + wobble(jit), by + side / 2 + wobble(jit));
            else
                push_point(bx + (k & 1) * side + wobble(jit),
                           by + (k >> 1) * side + wobble(jit));
        end
    endfunction

    function automatic void build_set(int side, int spread, bit go_big);
        int pick, groups, legs_roll, k, target, bx, by;
        set_len = 0;
        pick    = $urandom_range(0, 99);
        if (go_big || pick >= 92) begin
            // past the store capacity most of the time
            target = $urandom_range(30, 36);
            while (set_len < target) begin
                if ($urandom_range(0, 3) == 0)
                    add_noise(1);
                else
                    add_legs(side, 4);
            end
        end else if (pick < 55) begin
            add_noise($urandom_range(0, 1));
            groups = $urandom_range(1, 3);
            for (k = 0; k < groups; k++) begin
                legs_roll = $urandom_range(0, 99);
                add_legs(side, legs_roll < 70 ? 4 : (legs_roll < 85 ? 3 : 5));
            end
            add_noise($urandom_range(0, 2));
        end else if (pick < 75) begin
            bx     = any_coord();
            by     = any_coord();
            target = $urandom_range(3, 8);
            for (k = 0; k < target; k++)
                push_point(bx + wobble(spread), by + wobble(spread));
        end else begin
            add_noise($urandom_range(1, 6));
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_set_end <= last;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_set();
        int k;
        for (k = 0; k < set_len; k++)
            send_point(set_x[k], set_y[k], k == set_len - 1);
        items_sent += set_len;
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (board.outstanding() != 0 || o_busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_band(input int lo, input int hi);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_MIN_DIST;
        i_cfg_wdata <= DIST_W'(lo);
        @(negedge i_clk);
        i_cfg_idx   <= REG_MAX_DIST;
        i_cfg_wdata <= DIST_W'(hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_register(REG_MIN_DIST, DIST_W'(lo));
        board.set_register(REG_MAX_DIST, DIST_W'(hi));
        cur_lo = lo;
        cur_hi = hi;
    endtask

    initial begin
        int band_lo[NUM_PHASES];
        int band_hi[NUM_PHASES];
        int p, k, phase_start;
        band_lo     = '{0, 200, 150, 4095, 1000, 100};
        band_hi     = '{4095, 600, 450, 4095, 3000, 380};
        board       = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_point_x   = '0;
        i_point_y   = '0;
        i_set_end   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_MIN_DIST;
        i_cfg_wdata = '0;
        cycle_count = 0;
        idle_on     = 1'b1;
        cur_lo      = MIN_DIST_RST;
        cur_hi      = MAX_DIST_RST;
        items_sent  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sets too small to evaluate
        set_len = 0;
        push_point(-32768, 32767);
        send_set();
        set_len = 0;
        push_point(32767, -32768);
        push_point(32767 - 300, -32768);
        send_set();
        // exact square in the default band, centers land below zero
        set_len = 0;
        for (k = 0; k < 4; k++)
            push_point(-1000 + (k & 1) * 400, -1000 + (k >> 1) * 400);
        send_set();
        // far apart points, nothing found
        set_len = 0;
        push_point(-32768, -32768);
        push_point(32767, 32767);
        push_point(0, -1);
        send_set();
        // crossed bounds leave every point without neighbors
        wait_idle();
        write_band(4095, 0);
        set_len = 0;
        for (k = 0; k < 4; k++)
            push_point(500 + (k & 1) * 400, 700 + (k >> 1) * 400);
        send_set();

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_band(band_lo[p], band_hi[p]);
            idle_on     = (p != 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                build_set((cur_lo + cur_hi) / 2, cur_hi + 1,
                          p == 0 && items_sent == phase_start);
                send_set();
            end
        end

        wait_idle();
        if (board.mismatch_count == 0 && board.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dblg_pkg.sv
hw/rtl/dblg_ram.sv
hw/rtl/distance_band_leg_grouping_unit.sv
tb/tb_distance_band_leg_grouping_unit.sv
